[rtl/core/utn_pkg.sv]
`timescale 1ns / 1ps

package utn_pkg;

    localparam int NAME_ENTRIES = 64;
    localparam int UID_ENTRIES  = 64;
    localparam int UID_BYTES    = 7;
    localparam int NAME_BYTES   = 8;

    localparam int NAME_W     = NAME_BYTES * 8;
    localparam int UID_W      = UID_BYTES * 8;
    localparam int NAME_IDX_W = $clog2(NAME_ENTRIES);
    localparam int UID_IDX_W  = $clog2(UID_ENTRIES);
    localparam int NAME_CNT_W = $clog2(NAME_ENTRIES + 1);
    localparam int UID_CNT_W  = $clog2(UID_ENTRIES + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_ASSOC  = 1'b1;

    // Probe that walks the name chain, one cell per cycle.
    typedef struct packed {
        logic                  act;
        logic                  hit;
        logic [NAME_IDX_W-1:0] idx;
        logic [NAME_W-1:0]     data;
    } t_name_probe;

    // Probe that walks the UID chain, one cell per cycle.
    typedef struct packed {
        logic                  act;
        logic                  hit;
        logic [UID_IDX_W-1:0]  idx;
        logic [NAME_IDX_W-1:0] link;
    } t_uid_probe;

    typedef struct packed {
        logic                  en;
        logic [NAME_IDX_W-1:0] idx;
        logic [NAME_W-1:0]     data;
    } t_name_wr;

    typedef struct packed {
        logic                  en_uid;
        logic                  en_link;
        logic [UID_IDX_W-1:0]  idx;
        logic [UID_W-1:0]      uid;
        logic [NAME_IDX_W-1:0] link;
    } t_uid_wr;

    function automatic logic [NAME_W-1:0] name_key(input logic [63:0] name,
                                                   input logic [3:0]  len);
        logic [3:0]  l;
        logic [63:0] m;
        logic [63:0] v;
        l = (len > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : len;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (4'(b) < l) ? 8'hFF : 8'h00;
        end
        v = name & m;
        return v[NAME_W-1:0];
    endfunction

    function automatic logic [UID_W-1:0] uid_key(input logic [55:0] uid);
        logic [63:0] w;
        w = {8'b0, uid};
        return w[UID_W-1:0];
    endfunction

    function automatic logic [5:0] index6(input logic [NAME_IDX_W-1:0] idx);
        logic [NAME_IDX_W+5:0] w;
        w = {6'b0, idx};
        return w[5:0];
    endfunction

    function automatic logic [63:0] name_ext(input logic [NAME_W-1:0] data);
        logic [NAME_W+63:0] w;
        w = {64'b0, data};
        return w[63:0];
    endfunction

endpackage

[rtl/core/utn_name_cell.sv]
`timescale 1ns / 1ps

module utn_name_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [utn_pkg::NAME_IDX_W-1:0] i_index,
    input  logic [utn_pkg::NAME_CNT_W-1:0] i_count,
    input  logic                           i_read,
    input  logic [utn_pkg::NAME_W-1:0]     i_key,
    input  logic [utn_pkg::NAME_IDX_W-1:0] i_target,
    input  utn_pkg::t_name_wr              i_wr,
    input  utn_pkg::t_name_probe           i_probe,
    output utn_pkg::t_name_probe           o_probe
);

    logic [utn_pkg::NAME_W-1:0] r_entry;
    utn_pkg::t_name_probe       r_probe;
    utn_pkg::t_name_probe       n_probe;
    logic                       live;
    logic                       match;

    assign live = (utn_pkg::NAME_CNT_W'(i_index) < i_count);

    // In read mode the cell at the target index answers; otherwise a live
    // cell answers when its name equals the key. The first answer sticks.
    always_comb begin
        match = i_probe.act && !i_probe.hit &&
                (i_read ? (i_index == i_target) : (live && (r_entry == i_key)));
        n_probe = i_probe;
        if (match) begin
            n_probe.hit  = 1'b1;
            n_probe.idx  = i_index;
            n_probe.data = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_entry <= i_wr.data;
        end
    end

    assign o_probe = r_probe;

endmodule

[rtl/core/utn_uid_cell.sv]
`timescale 1ns / 1ps

module utn_uid_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [utn_pkg::UID_IDX_W-1:0] i_index,
    input  logic [utn_pkg::UID_CNT_W-1:0] i_count,
    input  logic [utn_pkg::UID_W-1:0]     i_key,
    input  utn_pkg::t_uid_wr              i_wr,
    input  utn_pkg::t_uid_probe           i_probe,
    output utn_pkg::t_uid_probe           o_probe
);

    logic [utn_pkg::UID_W-1:0]      r_uid;
    logic [utn_pkg::NAME_IDX_W-1:0] r_link;
    utn_pkg::t_uid_probe            r_probe;
    utn_pkg::t_uid_probe            n_probe;
    logic                           live;
    logic                           match;

    assign live = (utn_pkg::UID_CNT_W'(i_index) < i_count);

    always_comb begin
        match   = i_probe.act && !i_probe.hit && live && (r_uid == i_key);
        n_probe = i_probe;
        if (match) begin
            n_probe.hit  = 1'b1;
            n_probe.idx  = i_index;
            n_probe.link = r_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.idx == i_index) begin
            if (i_wr.en_uid) begin
                r_uid <= i_wr.uid;
            end
            if (i_wr.en_link) begin
                r_link <= i_wr.link;
            end
        end
    end

    assign o_probe = r_probe;

endmodule

[rtl/core/utn_name_chain.sv]
`timescale 1ns / 1ps

module utn_name_chain (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [utn_pkg::NAME_CNT_W-1:0] i_count,
    input  logic                           i_read,
    input  logic [utn_pkg::NAME_W-1:0]     i_key,
    input  logic [utn_pkg::NAME_IDX_W-1:0] i_target,
    input  utn_pkg::t_name_wr              i_wr,
    input  utn_pkg::t_name_probe           i_probe,
    output utn_pkg::t_name_probe           o_probe
);

    utn_pkg::t_name_probe link_probe [utn_pkg::NAME_ENTRIES+1];

    assign link_probe[0] = i_probe;

    for (genvar g = 0; g < utn_pkg::NAME_ENTRIES; g++) begin : g_cell
        utn_name_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (utn_pkg::NAME_IDX_W'(g)),
            .i_count  (i_count),
            .i_read   (i_read),
            .i_key    (i_key),
            .i_target (i_target),
            .i_wr     (i_wr),
            .i_probe  (link_probe[g]),
            .o_probe  (link_probe[g+1])
        );
    end

    assign o_probe = link_probe[utn_pkg::NAME_ENTRIES];

endmodule

[rtl/core/utn_uid_chain.sv]
`timescale 1ns / 1ps

module utn_uid_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [utn_pkg::UID_CNT_W-1:0] i_count,
    input  logic [utn_pkg::UID_W-1:0]     i_key,
    input  utn_pkg::t_uid_wr              i_wr,
    input  utn_pkg::t_uid_probe           i_probe,
    output utn_pkg::t_uid_probe           o_probe
);

    utn_pkg::t_uid_probe link_probe [utn_pkg::UID_ENTRIES+1];

    assign link_probe[0] = i_probe;

    for (genvar g = 0; g < utn_pkg::UID_ENTRIES; g++) begin : g_cell
        utn_uid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (utn_pkg::UID_IDX_W'(g)),
            .i_count (i_count),
            .i_key   (i_key),
            .i_wr    (i_wr),
            .i_probe (link_probe[g]),
            .o_probe (link_probe[g+1])
        );
    end

    assign o_probe = link_probe[utn_pkg::UID_ENTRIES];

endmodule

[rtl/core/uid_to_name_association_table.sv]
`timescale 1ns / 1ps

// UID-to-name association table. A command is taken when start is high and
// busy is low; busy then stays high until the result beat, which appears on
// o_status, o_name_out and o_name_index for exactly one cycle with o_done high.
// The receiver cannot stall, so sample the result in that cycle. Names and
// UIDs live in two rows of cells, and every search is a probe that walks its
// row one cell per cycle: the name and UID searches run side by side. The
// tables hold 64 name entries and 64 UID entries. o_done rises once both
// walks are through for an associate or a lookup miss; a lookup hit also
// waits for a second walk down the name row, which fetches the linked name.
// busy drops in the cycle of the result beat, so a new command can be taken
// there. After reset both tables are empty and no clearing pass is needed. An
// associate that would have to add a name or a UID to a full table changes
// nothing and reports full.
module uid_to_name_association_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [55:0] i_uid,
    input  logic [63:0] i_name_in,
    input  logic [3:0]  i_name_len,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [63:0] o_name_out,
    output logic [5:0]  o_name_index
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_READ   = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic                           r_mode, n_mode;
    logic [utn_pkg::UID_W-1:0]      r_uid_key, n_uid_key;
    logic [utn_pkg::NAME_W-1:0]     r_name_key, n_name_key;
    logic                           r_launch, n_launch;
    logic                           r_read, n_read;
    logic [utn_pkg::NAME_IDX_W-1:0] r_target, n_target;

    logic                           r_name_done, n_name_done;
    logic                           r_name_hit, n_name_hit;
    logic [utn_pkg::NAME_IDX_W-1:0] r_name_idx, n_name_idx;
    logic                           r_uid_done, n_uid_done;
    logic                           r_uid_hit, n_uid_hit;
    logic [utn_pkg::UID_IDX_W-1:0]  r_uid_idx, n_uid_idx;
    logic [utn_pkg::NAME_IDX_W-1:0] r_uid_link, n_uid_link;

    logic [utn_pkg::NAME_CNT_W-1:0] r_name_count, n_name_count;
    logic [utn_pkg::UID_CNT_W-1:0]  r_uid_count, n_uid_count;

    logic                           r_done, n_done;
    logic [1:0]                     r_status, n_status;
    logic [63:0]                    r_name_out, n_name_out;
    logic [5:0]                     r_name_index, n_name_index;

    utn_pkg::t_name_probe name_in_probe, name_out_probe;
    utn_pkg::t_uid_probe  uid_in_probe, uid_out_probe;
    utn_pkg::t_name_wr    name_wr;
    utn_pkg::t_uid_wr     uid_wr;

    logic                           full;
    logic [utn_pkg::NAME_IDX_W-1:0] use_name_idx;

    always_comb begin
        name_in_probe      = '0;
        name_in_probe.act  = r_launch;
        uid_in_probe       = '0;
        // The UID row is only walked by the search, not by the name fetch.
        uid_in_probe.act   = r_launch && !r_read;
    end

    utn_name_chain u_name_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_count  (r_name_count),
        .i_read   (r_read),
        .i_key    (r_name_key),
        .i_target (r_target),
        .i_wr     (name_wr),
        .i_probe  (name_in_probe),
        .o_probe  (name_out_probe)
    );

    utn_uid_chain u_uid_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (r_uid_count),
        .i_key   (r_uid_key),
        .i_wr    (uid_wr),
        .i_probe (uid_in_probe),
        .o_probe (uid_out_probe)
    );

    assign full = (!r_name_hit &&
                   (r_name_count == utn_pkg::NAME_CNT_W'(utn_pkg::NAME_ENTRIES))) ||
                  (!r_uid_hit &&
                   (r_uid_count == utn_pkg::UID_CNT_W'(utn_pkg::UID_ENTRIES)));

    assign use_name_idx = r_name_hit ? r_name_idx
                                     : r_name_count[utn_pkg::NAME_IDX_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_uid_key    = r_uid_key;
        n_name_key   = r_name_key;
        n_launch     = 1'b0;
        n_read       = r_read;
        n_target     = r_target;
        n_name_done  = r_name_done;
        n_name_hit   = r_name_hit;
        n_name_idx   = r_name_idx;
        n_uid_done   = r_uid_done;
        n_uid_hit    = r_uid_hit;
        n_uid_idx    = r_uid_idx;
        n_uid_link   = r_uid_link;
        n_name_count = r_name_count;
        n_uid_count  = r_uid_count;
        n_done       = 1'b0;
        n_status     = r_status;
        n_name_out   = r_name_out;
        n_name_index = r_name_index;
        name_wr      = '0;
        uid_wr       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode      = i_mode;
                    n_uid_key   = utn_pkg::uid_key(i_uid);
                    n_name_key  = utn_pkg::name_key(i_name_in, i_name_len);
                    n_launch    = 1'b1;
                    n_read      = 1'b0;
                    n_name_done = 1'b0;
                    n_uid_done  = 1'b0;
                    n_state     = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (name_out_probe.act) begin
                    n_name_done = 1'b1;
                    n_name_hit  = name_out_probe.hit;
                    n_name_idx  = name_out_probe.idx;
                end
                if (uid_out_probe.act) begin
                    n_uid_done = 1'b1;
                    n_uid_hit  = uid_out_probe.hit;
                    n_uid_idx  = uid_out_probe.idx;
                    n_uid_link = uid_out_probe.link;
                end
                if (r_name_done && r_uid_done) begin
                    if (r_mode == utn_pkg::MODE_LOOKUP) begin
                        if (r_uid_hit) begin
                            n_target = r_uid_link;
                            n_read   = 1'b1;
                            n_launch = 1'b1;
                            n_state  = S_READ;
                        end else begin
                            n_done       = 1'b1;
                            n_status     = utn_pkg::ST_MISS;
                            n_name_out   = '0;
                            n_name_index = '0;
                            n_state      = S_IDLE;
                        end
                    end else if (full) begin
                        n_done       = 1'b1;
                        n_status     = utn_pkg::ST_FULL;
                        n_name_out   = '0;
                        n_name_index = '0;
                        n_state      = S_IDLE;
                    end else begin
                        name_wr.en     = !r_name_hit;
                        name_wr.idx    = use_name_idx;
                        name_wr.data   = r_name_key;
                        uid_wr.en_uid  = !r_uid_hit;
                        uid_wr.en_link = 1'b1;
                        uid_wr.idx     = r_uid_hit ? r_uid_idx
                                                   : r_uid_count[utn_pkg::UID_IDX_W-1:0];
                        uid_wr.uid     = r_uid_key;
                        uid_wr.link    = use_name_idx;
                        if (!r_name_hit) begin
                            n_name_count = r_name_count + 1'b1;
                        end
                        if (!r_uid_hit) begin
                            n_uid_count = r_uid_count + 1'b1;
                        end
                        n_done       = 1'b1;
                        n_status     = utn_pkg::ST_OK;
                        n_name_out   = '0;
                        n_name_index = utn_pkg::index6(use_name_idx);
                        n_state      = S_IDLE;
                    end
                end
            end
            S_READ: begin
                if (name_out_probe.act) begin
                    n_done       = 1'b1;
                    n_status     = utn_pkg::ST_OK;
                    n_name_out   = utn_pkg::name_ext(name_out_probe.data);
                    n_name_index = utn_pkg::index6(r_target);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_launch     <= 1'b0;
            r_read       <= 1'b0;
            r_name_done  <= 1'b0;
            r_uid_done   <= 1'b0;
            r_name_count <= '0;
            r_uid_count  <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_launch     <= n_launch;
            r_read       <= n_read;
            r_name_done  <= n_name_done;
            r_uid_done   <= n_uid_done;
            r_name_count <= n_name_count;
            r_uid_count  <= n_uid_count;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_uid_key    <= n_uid_key;
        r_name_key   <= n_name_key;
        r_target     <= n_target;
        r_name_hit   <= n_name_hit;
        r_name_idx   <= n_name_idx;
        r_uid_hit    <= n_uid_hit;
        r_uid_idx    <= n_uid_idx;
        r_uid_link   <= n_uid_link;
        r_status     <= n_status;
        r_name_out   <= n_name_out;
        r_name_index <= n_name_index;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_name_out   = r_name_out;
    assign o_name_index = r_name_index;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result beat without a command in flight");

    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |-> busy)
        else $error("probe launched while idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_name_count <= utn_pkg::NAME_CNT_W'(utn_pkg::NAME_ENTRIES)) &&
        (r_uid_count <= utn_pkg::UID_CNT_W'(utn_pkg::UID_ENTRIES)))
        else $error("table fill count beyond depth");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import utn_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 300;
    localparam int STAGE_ITEMS = 610;
    localparam int POOL_SIZE   = 120;

    typedef struct {
        logic        mode;
        logic [55:0] uid;
        logic [63:0] name;
        logic [3:0]  len;
        bit          drain;
    } cmd_t;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] name;
        logic [5:0]  index;
    } answer_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_mode = MODE_LOOKUP;
    logic [55:0] i_uid = '0;
    logic [63:0] i_name_in = '0;
    logic [3:0]  i_name_len = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [63:0] o_name_out;
    logic [5:0]  o_name_index;

    uid_to_name_association_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_uid       (i_uid),
        .i_name_in   (i_name_in),
        .i_name_len  (i_name_len),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_name_out  (o_name_out),
        .o_name_index(o_name_index)
    );

    cmd_t    pending_cmds[$];
    answer_t answers_due[$];
    int      bad_count = 0;
    int      cycles = 0;
    bit      beat_taken = 1'b0;
    int      burst_left = 1;
    int      gap_left = 0;

    // Shadow copy of both tables.
    logic [NAME_W-1:0]     shadow_name[NAME_ENTRIES];
    logic [UID_W-1:0]      shadow_uid[UID_ENTRIES];
    logic [NAME_IDX_W-1:0] shadow_link[UID_ENTRIES];
    int                    shadow_name_cnt = 0;
    int                    shadow_uid_cnt = 0;

    logic [55:0] uid_pool[POOL_SIZE];
    logic [63:0] name_pool[POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic answer_t predict_answer(cmd_t c);
        answer_t     a;
        int          ui;
        int          ni;
        int          l;
        bit          uid_hit;
        bit          name_hit;
        logic [63:0] key;
        a = '{ST_OK, 64'd0, 6'd0};
        uid_hit = 1'b0;
        ui = 0;
        for (int k = 0; k < shadow_uid_cnt; k++) begin
            if (!uid_hit && shadow_uid[k] == c.uid[UID_W-1:0]) begin
                uid_hit = 1'b1;
                ui = k;
            end
        end
        if (c.mode == MODE_LOOKUP) begin
            if (uid_hit) begin
                a.name  = 64'(shadow_name[shadow_link[ui]]);
                a.index = 6'(shadow_link[ui]);
            end else begin
                a.status = ST_MISS;
            end
            return a;
        end
        l = (int'(c.len) > NAME_BYTES) ? NAME_BYTES : int'(c.len);
        key = '0;
        for (int b = 0; b < l; b++) begin
            key[8*b +: 8] = c.name[8*b +: 8];
        end
        name_hit = 1'b0;
        ni = 0;
        for (int k = 0; k < shadow_name_cnt; k++) begin
            if (!name_hit && shadow_name[k] == key[NAME_W-1:0]) begin
                name_hit = 1'b1;
                ni = k;
            end
        end
        // A full table rejects the whole associate and leaves both tables alone.
        if ((!name_hit && shadow_name_cnt >= NAME_ENTRIES) ||
            (!uid_hit && shadow_uid_cnt >= UID_ENTRIES)) begin
            a.status = ST_FULL;
            return a;
        end
        if (!name_hit) begin
            ni = shadow_name_cnt;
            shadow_name[ni] = key[NAME_W-1:0];
            shadow_name_cnt++;
        end
        if (!uid_hit) begin
            ui = shadow_uid_cnt;
            shadow_uid[ui] = c.uid[UID_W-1:0];
            shadow_uid_cnt++;
        end
        shadow_link[ui] = NAME_IDX_W'(ni);
        a.index = 6'(ni);
        return a;
    endfunction

    task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
        bad_count++;
        if (bad_count <= 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    task automatic add_cmd(logic mode, logic [55:0] uid, logic [63:0] name,
                           logic [3:0] len, bit drain);
        cmd_t c;
        c = '{mode, uid, name, len, drain};
        pending_cmds.push_back(c);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random stages: the first works a small set of UIDs and names, the second
    // brings in many names so the name list fills, and the third brings in many
    // UIDs and short names so the UID table fills too.
    task automatic add_random_stage(int stage);
        int          r;
        int          uid_hi;
        int          name_hi;
        logic [55:0] uid;
        logic [3:0]  len;
        uid_hi  = (stage == 0) ? 31 : (stage == 1) ? 47 : POOL_SIZE - 1;
        name_hi = (stage == 1) ? POOL_SIZE - 1 : 31;
        for (int n = 0; n < STAGE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            uid = uid_pool[$urandom_range(0, uid_hi)];
            if (r < 35) begin
                if ($urandom_range(0, 4) == 0) uid = 56'(rand64());
                add_cmd(MODE_LOOKUP, uid, rand64(), 4'($urandom_range(0, 15)), n == 0);
            end else if (stage == 2 && r < 42) begin
                add_cmd(MODE_ASSOC, 56'(rand64()), rand64(),
                        4'($urandom_range(0, 15)), n == 0);
            end else begin
                len = (stage == 2 && $urandom_range(0, 2) == 0) ?
                      4'($urandom_range(0, 15)) : 4'($urandom_range(8, 15));
                add_cmd(MODE_ASSOC, uid, name_pool[$urandom_range(0, name_hi)], len,
                        n == 0);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < POOL_SIZE; k++) begin
            uid_pool[k]  = 56'(rand64());
            name_pool[k] = rand64();
        end
        add_cmd(MODE_LOOKUP, 56'd0, 64'd0, 4'd0, 1'b0);
        add_cmd(MODE_ASSOC, 56'd0, '1, 4'd0, 1'b0);
        add_cmd(MODE_ASSOC, '1, '1, 4'd8, 1'b0);
        add_cmd(MODE_LOOKUP, '1, 64'd0, 4'd15, 1'b0);
        add_cmd(MODE_LOOKUP, 56'd0, '1, 4'd0, 1'b0);
        add_cmd(MODE_ASSOC, 56'h12_3456_789A_BCDE, '1, 4'd15, 1'b0);
        add_cmd(MODE_ASSOC, 56'h00_0000_0000_0001, 64'h0123_4567_89AB_CDEF, 4'd3, 1'b0);
        add_cmd(MODE_ASSOC, 56'd0, 64'hFFFF_FFFF_FFAB_CDEF, 4'd3, 1'b0);
        add_cmd(MODE_LOOKUP, 56'd0, 64'd0, 4'd0, 1'b0);
        add_cmd(MODE_LOOKUP, 56'h12_3456_789A_BCDE, 64'd0, 4'd0, 1'b0);
        add_cmd(MODE_ASSOC, 56'hAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1'b0);
        add_cmd(MODE_ASSOC, 56'h55_5555_5555_5555, 64'h5555_5555_5555_5555, 4'd9, 1'b0);
        for (int l = 1; l <= 7; l++) begin
            add_cmd(MODE_ASSOC, 56'(rand64()), 64'h5555_5555_5555_5555, 4'(l), 1'b0);
        end
        add_cmd(MODE_LOOKUP, 56'hAA_AAAA_AAAA_AAAA, 64'd0, 4'd0, 1'b0);
        add_cmd(MODE_LOOKUP, 56'h55_5555_5555_5555, 64'd0, 4'd0, 1'b0);
        add_cmd(MODE_LOOKUP, 56'h00_0000_0000_0001, 64'd0, 4'd0, 1'b0);
        add_cmd(MODE_LOOKUP, 56'(rand64()), 64'd0, 4'd0, 1'b0);
        for (int s = 0; s < 3; s++) add_random_stage(s);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (pending_cmds.size() != 0 || start ||
                                    answers_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Driver: a held start with busy high waits; once its beat is taken the
    // next command follows at once within a burst, otherwise after a random gap that may be empty.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (start) begin
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 10);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 140);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].drain && answers_due.size() != 0)) begin
                i_mode     <= pending_cmds[0].mode;
                i_uid      <= pending_cmds[0].uid;
                i_name_in  <= pending_cmds[0].name;
                i_name_len <= pending_cmds[0].len;
                void'(pending_cmds.pop_front());
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest expected answer and
    // predicts the answer of every command taken at this edge.
    always @(posedge i_clk) begin
        answer_t want;
        cmd_t    taken;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            if (o_done === 1'b1) begin
                if (answers_due.size() == 0) begin
                    note_mismatch("unexpected result", 64'd0, {62'd0, o_status});
                end else begin
                    want = answers_due.pop_front();
                    if (o_status !== want.status)
                        note_mismatch("status", 64'(want.status), 64'(o_status));
                    if (o_name_out !== want.name)
                        note_mismatch("name_out", want.name, o_name_out);
                    if (o_name_index !== want.index)
                        note_mismatch("name_index", 64'(want.index), 64'(o_name_index));
                end
            end
            if (start && busy === 1'b0) begin
                taken = '{i_mode, i_uid, i_name_in, i_name_len, 1'b0};
                answers_due.push_back(predict_answer(taken));
                beat_taken <= 1'b1;
            end else begin
                beat_taken <= 1'b0;
            end
        end
    end

endmodule

[uid_to_name_association_table.f]
rtl/core/utn_pkg.sv
rtl/core/utn_name_cell.sv
rtl/core/utn_uid_cell.sv
rtl/core/utn_name_chain.sv
rtl/core/utn_uid_chain.sv
rtl/core/uid_to_name_association_table.sv
verif/tb_top.sv
